// File: design/tfn_pkg.sv
`timescale 1ns / 1ps

package tfn_pkg;

    localparam int COORD_W  = 16;                 // input coordinate width, Q8.8
    localparam int EDGE_W   = COORD_W + 1;        // exact edge difference
    localparam int PROD_W   = 2 * EDGE_W;         // one partial product
    localparam int CROSS_W  = PROD_W + 1;         // cross product component
    localparam int MAG_W    = CROSS_W - 1;        // magnitude of a component
    localparam int BLEN_W   = $clog2(MAG_W + 1);  // bit length of a magnitude
    localparam int SCALE_B  = 31;                 // scaled magnitude width
    localparam int SQ_W     = 2 * SCALE_B;        // one square
    localparam int SUM_W    = 64;                 // sum of three squares
    localparam int ROOT_W   = SUM_W / 2;          // root width
    localparam int REM_W    = ROOT_W + 1;         // root remainder width
    localparam int FRAC_B   = 14;                 // output fraction bits
    localparam int NORM_W   = 16;                 // output component width
    localparam int QUO_W    = FRAC_B + 1;         // quotient width
    localparam int NUM_W    = SCALE_B + FRAC_B + 1; // rounded numerator width

    localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1) << FRAC_B;

    typedef struct packed {
        logic                           deg;
        logic [2:0]                     neg;
        logic [2:0][SCALE_B-1:0]        mag;
    } t_side;

    typedef struct packed {
        logic                           deg;
        logic [2:0]                     neg;
    } t_flags;

    function automatic logic [BLEN_W-1:0] bit_len(input logic [MAG_W-1:0] v);
        logic [BLEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                n = BLEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// File: design/tfn_isqrt.sv
`timescale 1ns / 1ps

// one root bit per stage, remainder and radicand travel along
module tfn_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [tfn_pkg::SUM_W-1:0]   i_rad,
    input  tfn_pkg::t_side              i_side,
    output logic                        o_vld,
    output logic [tfn_pkg::ROOT_W-1:0]  o_root,
    output tfn_pkg::t_side              o_side
);

    localparam int N = tfn_pkg::ROOT_W;

    // index k holds the state after root bit k
    logic [N-1:0]                         r_vld;
    logic [N-2:0][tfn_pkg::SUM_W-1:0]     r_rad;
    logic [N-2:0][tfn_pkg::REM_W-1:0]     r_rem;
    logic [N-1:0][tfn_pkg::ROOT_W-1:0]    r_root;
    tfn_pkg::t_side [N-1:0]               r_side;

    // stage inputs, stage 0 fed from the ports
    logic [N-1:0][tfn_pkg::SUM_W-1:0]     w_rad;
    logic [N-1:0][tfn_pkg::REM_W-1:0]     w_rem;
    logic [N-1:0][tfn_pkg::ROOT_W-1:0]    w_root;

    logic [N-1:0][tfn_pkg::REM_W+1:0]     n_trial;
    logic [N-1:0][tfn_pkg::REM_W+1:0]     n_cmp;
    logic [N-1:0]                         n_ge;
    logic [N-2:0][tfn_pkg::REM_W-1:0]     n_rem;
    logic [N-2:0][tfn_pkg::SUM_W-1:0]     n_rad;
    logic [N-1:0][tfn_pkg::ROOT_W-1:0]    n_root;

    assign w_rad  = {r_rad, i_rad};
    assign w_rem  = {r_rem, tfn_pkg::REM_W'(0)};
    assign w_root = {r_root[N-2:0], tfn_pkg::ROOT_W'(0)};

    always_comb begin
        for (int k = 0; k < N; k++) begin
            n_trial[k] = {w_rem[k], w_rad[k][tfn_pkg::SUM_W-1 -: 2]};
            n_cmp[k]   = {1'b0, w_root[k], 2'b01};
            n_ge[k]    = (n_trial[k] >= n_cmp[k]);
            n_root[k]  = {w_root[k][N-2:0], n_ge[k]};
        end
        for (int k = 0; k < N - 1; k++) begin
            n_rem[k] = n_ge[k] ? tfn_pkg::REM_W'(n_trial[k] - n_cmp[k])
                               : n_trial[k][tfn_pkg::REM_W-1:0];
            n_rad[k] = {w_rad[k][tfn_pkg::SUM_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_vld};
        end
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= {r_side[N-2:0], i_side};
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_root = r_root[N-1];
    assign o_side = r_side[N-1];

endmodule

// File: design/tfn_div.sv
`timescale 1ns / 1ps

// three restoring dividers side by side, one quotient bit per stage
module tfn_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  logic [tfn_pkg::ROOT_W-1:0]          i_len,
    input  tfn_pkg::t_side                      i_side,
    output logic                                o_vld,
    output logic [2:0][tfn_pkg::QUO_W-1:0]      o_quo,
    output tfn_pkg::t_flags                     o_flags
);

    localparam int N  = tfn_pkg::QUO_W;
    localparam int DW = tfn_pkg::ROOT_W + N;

    // index 0 is the entry register, step s reads index s
    logic [N:0]                             r_vld;
    logic [N-1:0][tfn_pkg::ROOT_W-1:0]      r_len;
    logic [N-1:0][2:0][DW-1:0]              r_rem;
    logic [N-1:0][2:0][N-1:0]               r_quo;
    tfn_pkg::t_flags [N:0]                  r_flg;

    tfn_pkg::t_flags                        w_flg_in;
    logic [N-1:0][2:0][N-1:0]               w_qin;
    logic [2:0][DW-1:0]                     n_num;
    logic [N-1:0][DW:0]                     n_dsh;
    logic [N-1:0][2:0]                      n_ge;
    logic [N-2:0][2:0][DW-1:0]              n_rem;
    logic [N-1:0][2:0][N-1:0]               n_quo;

    assign w_qin = {r_quo[N-2:0], (3 * N)'(0)};

    always_comb begin
        w_flg_in.deg = i_side.deg;
        w_flg_in.neg = i_side.neg;
        // numerator with half the divisor added for rounding
        for (int c = 0; c < 3; c++) begin
            n_num[c] = DW'({i_side.mag[c], tfn_pkg::FRAC_B'(0)}) + DW'(i_len >> 1);
        end
        for (int s = 0; s < N; s++) begin
            n_dsh[s] = (DW + 1)'(r_len[s]) << (N - 1 - s);
            for (int c = 0; c < 3; c++) begin
                n_ge[s][c]  = ({1'b0, r_rem[s][c]} >= n_dsh[s]);
                n_quo[s][c] = w_qin[s][c] | (n_ge[s][c] ? (N'(1) << (N - 1 - s)) : N'(0));
            end
        end
        for (int s = 0; s < N - 1; s++) begin
            for (int c = 0; c < 3; c++) begin
                n_rem[s][c] = n_ge[s][c] ? DW'({1'b0, r_rem[s][c]} - n_dsh[s])
                                         : r_rem[s][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-1:0], i_vld};
        end
        if (i_en) begin
            r_len <= {r_len[N-2:0], i_len};
            r_flg <= {r_flg[N-1:0], w_flg_in};
            r_rem <= {n_rem, n_num};
            r_quo <= n_quo;
        end
    end

    assign o_vld   = r_vld[N];
    assign o_quo   = r_quo[N-1];
    assign o_flags = r_flg[N];

endmodule

// File: design/triangle_face_normal.sv
`timescale 1ns / 1ps

// Unit face normal of a triangle. Each input word carries three vertices
// in signed Q8.8; the block forms the edges b-a and c-a, their exact cross
// product, block-scales it to 31 bits, takes the exact integer square root
// of the sum of squares and divides each component by that length with
// round half up, giving signed Q1.14 components. A triangle with a zero
// cross product gives a zero normal and sets the degenerate flag in tuser.
// The datapath is a fully pipelined chain of 56 register stages: one
// triangle enters every clock while the output is not stalled. The root
// extractor takes one bit per stage over 32 stages, and the dividers an
// entry register, then one quotient bit per stage, 16 stages in all.
// The whole pipe advances together; it halts only when a result sits in
// the output register and the downstream side is not ready.
module triangle_face_normal (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 16 bits each, from bit 0
    input  logic [143:0]    i_s_axis_tdata,
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    // norm_x, norm_y, norm_z, 16 bits each, from bit 0
    output logic [47:0]     o_m_axis_tdata,
    // degenerate
    output logic            o_m_axis_tuser,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready
);

    localparam int CW = tfn_pkg::COORD_W;

    // global advance: the pipe moves unless the output word is stuck
    logic w_en;

    logic [7:1]                                 r_vld;
    logic signed [2:0][tfn_pkg::EDGE_W-1:0]     r_e1, r_e2;
    logic signed [5:0][tfn_pkg::PROD_W-1:0]     r_prod;
    logic [2:0][tfn_pkg::MAG_W-1:0]             r_mag3, r_mag4;
    logic [2:0]                                 r_neg3, r_neg4, r_neg5, r_neg6, r_neg7;
    logic [tfn_pkg::BLEN_W-1:0]                 r_blen;
    logic                                       r_deg4, r_deg5, r_deg6, r_deg7;
    logic [2:0][tfn_pkg::SCALE_B-1:0]           r_sm5, r_sm6, r_sm7;
    logic [2:0][tfn_pkg::SQ_W-1:0]              r_sq;
    logic [tfn_pkg::SUM_W-1:0]                  r_sum;

    logic                                       w_sq_vld;
    logic [tfn_pkg::ROOT_W-1:0]                 w_root;
    tfn_pkg::t_side                             w_side_in, w_side_out;
    logic                                       w_dv_vld;
    logic [2:0][tfn_pkg::QUO_W-1:0]             w_quo;
    tfn_pkg::t_flags                            w_flags;

    logic                                       r_o_vld;
    logic [2:0][tfn_pkg::NORM_W-1:0]            r_norm;
    logic                                       r_o_deg;
    logic [2:0][tfn_pkg::NORM_W-1:0]            n_norm;

    assign w_en            = !r_o_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[6:1], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // edges, exact
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= tfn_pkg::EDGE_W'($signed(i_s_axis_tdata[(3+i)*CW +: CW]))
                         - tfn_pkg::EDGE_W'($signed(i_s_axis_tdata[i*CW +: CW]));
                r_e2[i] <= tfn_pkg::EDGE_W'($signed(i_s_axis_tdata[(6+i)*CW +: CW]))
                         - tfn_pkg::EDGE_W'($signed(i_s_axis_tdata[i*CW +: CW]));
            end
            // six partial products of the cross product
            r_prod[0] <= $signed(r_e1[1]) * $signed(r_e2[2]);
            r_prod[1] <= $signed(r_e1[2]) * $signed(r_e2[1]);
            r_prod[2] <= $signed(r_e1[2]) * $signed(r_e2[0]);
            r_prod[3] <= $signed(r_e1[0]) * $signed(r_e2[2]);
            r_prod[4] <= $signed(r_e1[0]) * $signed(r_e2[1]);
            r_prod[5] <= $signed(r_e1[1]) * $signed(r_e2[0]);
            // cross components, split into sign and magnitude
            for (int i = 0; i < 3; i++) begin
                logic signed [tfn_pkg::CROSS_W-1:0] cr;
                cr = tfn_pkg::CROSS_W'($signed(r_prod[2*i]))
                   - tfn_pkg::CROSS_W'($signed(r_prod[2*i+1]));
                r_neg3[i] <= cr[tfn_pkg::CROSS_W-1];
                r_mag3[i] <= cr[tfn_pkg::CROSS_W-1]
                           ? tfn_pkg::MAG_W'(-cr) : tfn_pkg::MAG_W'(cr);
            end
            // bit length of the largest magnitude equals that of the or
            r_blen <= tfn_pkg::bit_len(r_mag3[0] | r_mag3[1] | r_mag3[2]);
            r_deg4 <= ~|(r_mag3[0] | r_mag3[1] | r_mag3[2]);
            r_mag4 <= r_mag3;
            r_neg4 <= r_neg3;
            // block scale: largest lands in [2^30, 2^31)
            for (int i = 0; i < 3; i++) begin
                logic [tfn_pkg::MAG_W+tfn_pkg::SCALE_B-1:0] ext;
                ext = {r_mag4[i], tfn_pkg::SCALE_B'(0)} >> r_blen;
                r_sm5[i] <= ext[tfn_pkg::SCALE_B-1:0];
            end
            r_deg5 <= r_deg4;
            r_neg5 <= r_neg4;
            // squares
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= tfn_pkg::SQ_W'(r_sm5[i]) * tfn_pkg::SQ_W'(r_sm5[i]);
            end
            r_sm6  <= r_sm5;
            r_deg6 <= r_deg5;
            r_neg6 <= r_neg5;
            // sum of squares
            r_sum  <= tfn_pkg::SUM_W'(r_sq[0]) + tfn_pkg::SUM_W'(r_sq[1])
                    + tfn_pkg::SUM_W'(r_sq[2]);
            r_sm7  <= r_sm6;
            r_deg7 <= r_deg6;
            r_neg7 <= r_neg6;
        end
    end

    always_comb begin
        w_side_in.deg = r_deg7;
        w_side_in.neg = r_neg7;
        w_side_in.mag = r_sm7;
    end

    assign w_sq_vld = r_vld[7];

    tfn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_rad   (r_sum),
        .i_side  (w_side_in),
        .o_vld   (w_dv_vld),
        .o_root  (w_root),
        .o_side  (w_side_out)
    );

    logic                   w_q_vld;

    tfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_dv_vld),
        .i_len   (w_root),
        .i_side  (w_side_out),
        .o_vld   (w_q_vld),
        .o_quo   (w_quo),
        .o_flags (w_flags)
    );

    // saturate, apply sign, zero for a degenerate triangle
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [tfn_pkg::QUO_W-1:0] q;
            q = (w_quo[i] > tfn_pkg::ONE_Q) ? tfn_pkg::ONE_Q : w_quo[i];
            if (w_flags.deg) begin
                n_norm[i] = '0;
            end else if (w_flags.neg[i]) begin
                n_norm[i] = tfn_pkg::NORM_W'(-{1'b0, q});
            end else begin
                n_norm[i] = tfn_pkg::NORM_W'({1'b0, q});
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= w_q_vld;
        end
        if (w_en) begin
            r_norm  <= n_norm;
            r_o_deg <= w_flags.deg;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = r_norm;
    assign o_m_axis_tuser  = r_o_deg;

    // a degenerate word carries a zero normal
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_deg |-> r_norm == '0)
        else $error("degenerate word with nonzero normal");

    // components stay within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> ($signed(r_norm[0]) <= 16384 && $signed(r_norm[0]) >= -16384
                  && $signed(r_norm[1]) <= 16384 && $signed(r_norm[1]) >= -16384
                  && $signed(r_norm[2]) <= 16384 && $signed(r_norm[2]) >= -16384))
        else $error("normal component out of range");

    // a stall freezes the front valid bits
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipe moved during stall");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

// File: tb/triangle_face_normal_checker.sv
`timescale 1ns / 1ps

module triangle_face_normal_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [143:0]    i_s_tdata,
    input  logic            i_s_tvalid,
    input  logic            i_s_tready,
    input  logic [47:0]     i_m_tdata,
    input  logic            i_m_tuser,
    input  logic            i_m_tvalid,
    input  logic            i_m_tready,
    output int              o_fail_count,
    output int              o_pending
);

    typedef struct packed {
        logic        degenerate;
        logic [47:0] normal;
    } t_normal;

    t_normal normal_q[$];

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // face normal of one triangle word
    function automatic t_normal face_normal(input logic [143:0] w);
        longint      p[9];
        longint      e1[3], e2[3], cr[3];
        logic [63:0] mag[3];
        logic [63:0] maxm, sum, len, q;
        int          blen;
        t_normal     r;
        for (int i = 0; i < 9; i++) p[i] = longint'($signed(w[16*i +: 16]));
        for (int i = 0; i < 3; i++) begin
            e1[i] = p[3+i] - p[i];
            e2[i] = p[6+i] - p[i];
        end
        cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
        cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
        cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
        maxm = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = cr[i] < 0 ? 64'(-cr[i]) : 64'(cr[i]);
            if (mag[i] > maxm) maxm = mag[i];
        end
        r = '0;
        if (maxm == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        blen = 0;
        for (int i = 0; i < 64; i++) if (maxm[i]) blen = i + 1;
        for (int i = 0; i < 3; i++) begin
            if (blen < 31) mag[i] = mag[i] << (31 - blen);
            else if (blen > 31) mag[i] = mag[i] >> (blen - 31);
        end
        sum = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
        len = root64(sum);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 14) + (len >> 1)) / len;
            if (q > (64'd1 << 14)) q = 64'd1 << 14;
            r.normal[16*i +: 16] = cr[i] < 0 ? 16'(-q) : 16'(q);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_normal exp_n;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) normal_q = {normal_q, face_normal(i_s_tdata)};
            if (i_m_tvalid && i_m_tready) begin
                if (normal_q.size() == 0) begin
                    $display("%0t unexpected word %h user %b", $time, i_m_tdata, i_m_tuser);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_n = normal_q.pop_front();
                    if (exp_n.normal !== i_m_tdata || exp_n.degenerate !== i_m_tuser) begin
                        $display("%0t mismatch expected %h/%b actual %h/%b", $time,
                                 exp_n.normal, exp_n.degenerate, i_m_tdata, i_m_tuser);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= normal_q.size();
        end
    end

endmodule

// File: tb/triangle_face_normal_test.sv
`timescale 1ns / 1ps

module triangle_face_normal_test;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic [143:0]   s_tdata = '0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [47:0]    m_tdata;
    logic           m_tuser;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    int             fail_count;
    int             pending;
    int             send_idle_pct = 0;   // sender gap odds in percent
    int             recv_stall_pct = 0;  // receiver stall odds in percent
    int             hold_cycles = 0;     // long receiver hold-off when nonzero

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    triangle_face_normal dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready)
    );

    triangle_face_normal_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: random stalls, or a long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one triangle word, with random idle cycles ahead of it
    task automatic send_triangle(input logic [143:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    function automatic logic [143:0] pack_tri(input logic [15:0] c[9]);
        logic [143:0] w;
        for (int i = 0; i < 9; i++) w[16*i +: 16] = c[i];
        return w;
    endfunction

    // random triangle: full range, small local triangles, collinear ones or extreme corners
    function automatic logic [143:0] random_triangle();
        logic [15:0] c[9];
        int          kind;
        int          k;
        kind = $urandom_range(9);
        for (int i = 0; i < 9; i++) c[i] = 16'($urandom);
        if (kind < 4) begin
            // small edges around the first vertex
            for (int i = 3; i < 9; i++)
                c[i] = c[i%3] + 16'($signed($urandom_range(64)) - 32);
        end else if (kind == 4) begin
            // collinear: third vertex on the line a + k*(b-a)
            k = $urandom_range(3);
            for (int i = 0; i < 3; i++) c[6+i] = c[i] + 16'(k) * (c[3+i] - c[i]);
        end else if (kind == 5) begin
            for (int i = 0; i < 9; i++)
                c[i] = $urandom_range(1) ? 16'h8000 : 16'h7fff;
        end
        return pack_tri(c);
    endfunction

    initial begin
        logic [15:0] c[9];
        int          phase_items;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: coincident, collinear, axis-aligned, extremes
        c = '{default: 16'h0};
        send_triangle(pack_tri(c));
        c = '{16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0200, 16'h0, 16'h0};
        send_triangle(pack_tri(c));
        c = '{16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0};
        send_triangle(pack_tri(c));
        c = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100};
        send_triangle(pack_tri(c));
        c = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0, 16'h0};
        send_triangle(pack_tri(c));
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
              16'h8000, 16'h7fff, 16'h8000};
        send_triangle(pack_tri(c));
        c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
              16'h8000, 16'h8000, 16'h7fff};
        send_triangle(pack_tri(c));
        c = '{16'hffff, 16'hffff, 16'hffff, 16'h0, 16'hffff, 16'hffff,
              16'hffff, 16'h0, 16'hffff};
        send_triangle(pack_tri(c));
        c = '{16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0001};
        send_triangle(pack_tri(c));
        c = '{16'h1234, 16'h1234, 16'h1234, 16'h1235, 16'h1235, 16'h1235,
              16'h1236, 16'h1236, 16'h1237};
        send_triangle(pack_tri(c));

        // random phases: idle mixes, then a long hold-off
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
                default: begin
                    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 300;
                end
            endcase
            phase_items = (ph == 4) ? 200 : 350;
            for (int n = 0; n < phase_items; n++) send_triangle(random_triangle());
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
design/tfn_pkg.sv
design/tfn_isqrt.sv
design/tfn_div.sv
design/triangle_face_normal.sv
tb/triangle_face_normal_checker.sv
tb/triangle_face_normal_test.sv
